FILE: rtl/core/syip_pkg.sv
// Package for the shunting-yard infix to postfix converter.
// Holds token, result and error codes, sequencer types and default sizes.
// No dependencies.
package syip_pkg;

  localparam int STACK_DEPTH_DEF     = 16;
  localparam int MAX_PAREN_DEPTH_DEF = 15;
  localparam int PAYLOAD_WIDTH_DEF   = 32;

  localparam int LevelStep = 100;
  localparam int CfgW      = 7;
  localparam int CmdW      = 3;
  localparam int OpW       = 3;
  localparam int KindW     = 2;
  localparam int ErrW      = 3;
  localparam int NumOps    = 6;
  localparam int CfgIdxW   = 2;

  localparam logic [CmdW-1:0] CMD_OPERAND  = 3'd0;
  localparam logic [CmdW-1:0] CMD_LPAREN   = 3'd1;
  localparam logic [CmdW-1:0] CMD_OPERATOR = 3'd2;
  localparam logic [CmdW-1:0] CMD_RPAREN   = 3'd3;
  localparam logic [CmdW-1:0] CMD_END      = 3'd4;

  localparam logic [OpW-1:0] OP_DSTAR = 3'd0;
  localparam logic [OpW-1:0] OP_CARET = 3'd1;
  localparam logic [OpW-1:0] OP_MUL   = 3'd2;
  localparam logic [OpW-1:0] OP_DIV   = 3'd3;
  localparam logic [OpW-1:0] OP_ADD   = 3'd4;
  localparam logic [OpW-1:0] OP_SUB   = 3'd5;
  localparam logic [OpW-1:0] OP_NONE  = 3'd0;

  localparam logic [KindW-1:0] KIND_OPERAND  = 2'd0;
  localparam logic [KindW-1:0] KIND_OPERATOR = 2'd1;
  localparam logic [KindW-1:0] KIND_ACCEPT   = 2'd2;
  localparam logic [KindW-1:0] KIND_ERROR    = 2'd3;

  localparam logic [ErrW-1:0] ERR_NONE        = 3'd0;
  localparam logic [ErrW-1:0] ERR_OPERAND_POS = 3'd1;
  localparam logic [ErrW-1:0] ERR_OPERATOR_POS = 3'd2;
  localparam logic [ErrW-1:0] ERR_UNMATCHED_R = 3'd3;
  localparam logic [ErrW-1:0] ERR_UNMATCHED_L = 3'd4;
  localparam logic [ErrW-1:0] ERR_STACK_OVF   = 3'd5;
  localparam logic [ErrW-1:0] ERR_DEPTH_OVF   = 3'd6;

  localparam logic [CfgIdxW-1:0] REG_PREC_POWER  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PREC_MULDIV = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PREC_ADDSUB = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_LEFT_MASK   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_POPCHK,
    S_RESOLVE,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    M_OPER,
    M_RPAREN,
    M_END
  } mode_t;

endpackage

FILE: rtl/core/syip_stack.sv
// Operator stack storage: one write port and one registered read port.
// Depends on nothing; sized by its parameters.
module syip_stack #(
  parameter int DATA_W = 15,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/syip_cmp.sv
// Precedence compare unit shared by every pop decision.
// Depends on nothing; the width comes from its parameter.
module syip_cmp #(
  parameter int PREC_W = 11
) (
  input  logic [PREC_W-1:0] entry_prec,
  input  logic              entry_left,
  input  logic [PREC_W-1:0] target,
  input  logic              force_pop,
  output logic              pop
);

  // An entry leaves when forced, binds tighter, or ties and is left associative.
  assign pop = force_pop || (entry_prec > target) ||
               ((entry_prec == target) && entry_left);

endmodule

FILE: rtl/core/shunting_yard_infix_to_postfix.sv
// Top level of the shunting-yard infix to postfix converter.
// Depends on syip_pkg, syip_stack and syip_cmp.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_stall    | command, op_code, token_payload
//  output   | out_valid / out_stall  | out_kind, out_op, out_payload, error_code, last
//  config   | cfg_we                 | cfg_index, cfg_data
//
// An operand, a '(' or a request that fails or is ignored at decode returns to idle.
// An operator, ')' or end request runs fetch, a pop check unless the stack is empty,
// resolve and finish, with fetch and pop check again for each operator popped: each
// pop is one stack memory read followed by one compare unit pass. Reset empties the
// stack, clears the depth and expects an operand. A stalled output holds the sequencer.
module shunting_yard_infix_to_postfix #(
  parameter int STACK_DEPTH     = syip_pkg::STACK_DEPTH_DEF,
  parameter int MAX_PAREN_DEPTH = syip_pkg::MAX_PAREN_DEPTH_DEF,
  parameter int PAYLOAD_WIDTH   = syip_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [syip_pkg::CmdW-1:0]    command,
  input  logic [syip_pkg::OpW-1:0]     op_code,
  input  logic [PAYLOAD_WIDTH-1:0]     token_payload,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [syip_pkg::KindW-1:0]   out_kind,
  output logic [syip_pkg::OpW-1:0]     out_op,
  output logic [PAYLOAD_WIDTH-1:0]     out_payload,
  output logic [syip_pkg::ErrW-1:0]    error_code,
  output logic                         last,
  input  logic                         cfg_we,
  input  logic [syip_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [syip_pkg::CfgW-1:0]    cfg_data
);

  localparam int PREC_W  = $clog2(syip_pkg::LevelStep * MAX_PAREN_DEPTH
                                  + (1 << syip_pkg::CfgW));
  localparam int DEPTH_W = $clog2(MAX_PAREN_DEPTH + 1);
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W   = $clog2(STACK_DEPTH);
  localparam int ENTRY_W = PREC_W + syip_pkg::OpW + 1;

  logic [syip_pkg::CfgW-1:0]   prec_power;
  logic [syip_pkg::CfgW-1:0]   prec_muldiv;
  logic [syip_pkg::CfgW-1:0]   prec_addsub;
  logic [syip_pkg::NumOps-1:0] left_assoc_mask;

  syip_pkg::state_t state;
  syip_pkg::state_t state_next;
  syip_pkg::mode_t  mode;

  logic [syip_pkg::CmdW-1:0] cmd_q;
  logic [syip_pkg::OpW-1:0]  op_q;
  logic [PAYLOAD_WIDTH-1:0]  payload_q;
  logic [PREC_W-1:0]         target;
  logic [CNT_W-1:0]          stack_count;
  logic [DEPTH_W-1:0]        paren_depth;
  logic                      expect_operand;

  logic                      pend_valid;
  logic [syip_pkg::KindW-1:0] pend_kind;
  logic [syip_pkg::OpW-1:0]  pend_op;
  logic [syip_pkg::ErrW-1:0] pend_err;

  logic                      can_emit;
  logic                      pend_ok;
  logic [CNT_W-1:0]          cnt_m1;
  logic [PREC_W-1:0]         level;
  logic [PREC_W-1:0]         op_prec;
  logic [syip_pkg::CfgW-1:0] base;
  logic [ENTRY_W-1:0]        rd_entry;
  logic [ENTRY_W-1:0]        wr_entry;
  logic                      do_pop;

  logic                      dir_load;
  logic [syip_pkg::KindW-1:0] dir_kind;
  logic [syip_pkg::ErrW-1:0] dir_err;
  logic                      pnd_load;
  logic [syip_pkg::KindW-1:0] pnd_kind;
  logic [syip_pkg::OpW-1:0]  pnd_op;
  logic [syip_pkg::ErrW-1:0] pnd_err;
  logic                      pnd_flush;
  logic                      act_clear;
  logic                      act_push;
  logic                      act_pop;
  logic                      act_inc;
  logic                      act_dec;
  logic                      act_operand;
  logic                      act_start;
  syip_pkg::mode_t           start_mode;
  logic [PREC_W-1:0]         start_target;

  assign in_stall = (state != syip_pkg::S_IDLE);
  assign can_emit = !out_valid || !out_stall;
  assign pend_ok  = !pend_valid || can_emit;
  assign cnt_m1   = stack_count - CNT_W'(1);
  assign level    = PREC_W'(paren_depth) * PREC_W'(syip_pkg::LevelStep);

  always_comb begin
    case (op_q) inside
      syip_pkg::OP_DSTAR, syip_pkg::OP_CARET: base = prec_power;
      syip_pkg::OP_MUL, syip_pkg::OP_DIV:     base = prec_muldiv;
      default:                                base = prec_addsub;
    endcase
  end

  assign op_prec  = PREC_W'(base) + level;
  assign wr_entry = {target, op_q, left_assoc_mask[op_q]};

  syip_stack #(
    .DATA_W (ENTRY_W),
    .DEPTH  (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (act_push),
    .waddr (stack_count[IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (cnt_m1[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  syip_cmp #(
    .PREC_W (PREC_W)
  ) u_cmp (
    .entry_prec (rd_entry[ENTRY_W-1 -: PREC_W]),
    .entry_left (rd_entry[0]),
    .target     (target),
    .force_pop  (mode == syip_pkg::M_END),
    .pop        (do_pop)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      syip_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = syip_pkg::S_DECODE;
        end
      end
      syip_pkg::S_DECODE: begin
        if (act_start) begin
          state_next = syip_pkg::S_FETCH;
        end else if (dir_load || act_inc || act_operand || cmd_q > syip_pkg::CMD_END) begin
          state_next = syip_pkg::S_IDLE;
        end
      end
      syip_pkg::S_FETCH: begin
        state_next = (stack_count == '0) ? syip_pkg::S_RESOLVE : syip_pkg::S_POPCHK;
      end
      syip_pkg::S_POPCHK: begin
        if (!do_pop) begin
          state_next = syip_pkg::S_RESOLVE;
        end else if (pend_ok) begin
          state_next = syip_pkg::S_FETCH;
        end
      end
      syip_pkg::S_RESOLVE: begin
        if (pnd_load || act_push || act_dec) begin
          state_next = syip_pkg::S_FINISH;
        end
      end
      syip_pkg::S_FINISH: begin
        if (!pend_valid || can_emit) begin
          state_next = syip_pkg::S_IDLE;
        end
      end
      default: state_next = syip_pkg::S_IDLE;
    endcase
  end

  // Sequencer actions.
  always_comb begin
    dir_load     = 1'b0;
    dir_kind     = syip_pkg::KIND_ERROR;
    dir_err      = syip_pkg::ERR_NONE;
    pnd_load     = 1'b0;
    pnd_kind     = syip_pkg::KIND_ERROR;
    pnd_op       = syip_pkg::OP_NONE;
    pnd_err      = syip_pkg::ERR_NONE;
    pnd_flush    = 1'b0;
    act_clear    = 1'b0;
    act_push     = 1'b0;
    act_pop      = 1'b0;
    act_inc      = 1'b0;
    act_dec      = 1'b0;
    act_operand  = 1'b0;
    act_start    = 1'b0;
    start_mode   = syip_pkg::M_END;
    start_target = '0;
    unique case (state)
      syip_pkg::S_IDLE: begin
      end
      syip_pkg::S_DECODE: begin
        if (cmd_q <= syip_pkg::CMD_END) begin
          if (expect_operand) begin
            if (cmd_q == syip_pkg::CMD_OPERAND) begin
              if (can_emit) begin
                dir_load    = 1'b1;
                dir_kind    = syip_pkg::KIND_OPERAND;
                act_operand = 1'b1;
              end
            end else if (cmd_q == syip_pkg::CMD_LPAREN) begin
              if (paren_depth >= DEPTH_W'(MAX_PAREN_DEPTH)) begin
                if (can_emit) begin
                  dir_load  = 1'b1;
                  dir_err   = syip_pkg::ERR_DEPTH_OVF;
                  act_clear = 1'b1;
                end
              end else begin
                act_inc = 1'b1;
              end
            end else if (can_emit) begin
              dir_load  = 1'b1;
              dir_err   = syip_pkg::ERR_OPERAND_POS;
              act_clear = 1'b1;
            end
          end else begin
            if (cmd_q == syip_pkg::CMD_OPERAND || cmd_q == syip_pkg::CMD_LPAREN ||
                (cmd_q == syip_pkg::CMD_OPERATOR && op_q > syip_pkg::OP_SUB)) begin
              if (can_emit) begin
                dir_load  = 1'b1;
                dir_err   = syip_pkg::ERR_OPERATOR_POS;
                act_clear = 1'b1;
              end
            end else if (cmd_q == syip_pkg::CMD_OPERATOR) begin
              act_start    = 1'b1;
              start_mode   = syip_pkg::M_OPER;
              start_target = op_prec;
            end else if (cmd_q == syip_pkg::CMD_RPAREN) begin
              if (paren_depth == '0) begin
                if (can_emit) begin
                  dir_load  = 1'b1;
                  dir_err   = syip_pkg::ERR_UNMATCHED_R;
                  act_clear = 1'b1;
                end
              end else begin
                act_start    = 1'b1;
                start_mode   = syip_pkg::M_RPAREN;
                start_target = level;
              end
            end else begin
              act_start  = 1'b1;
              start_mode = syip_pkg::M_END;
            end
          end
        end
      end
      syip_pkg::S_FETCH: begin
      end
      syip_pkg::S_POPCHK: begin
        if (do_pop && pend_ok) begin
          pnd_load = 1'b1;
          pnd_kind = syip_pkg::KIND_OPERATOR;
          pnd_op   = rd_entry[1 +: syip_pkg::OpW];
          act_pop  = 1'b1;
        end
      end
      syip_pkg::S_RESOLVE: begin
        unique case (mode)
          syip_pkg::M_OPER: begin
            if (stack_count >= CNT_W'(STACK_DEPTH)) begin
              if (pend_ok) begin
                pnd_load  = 1'b1;
                pnd_err   = syip_pkg::ERR_STACK_OVF;
                act_clear = 1'b1;
              end
            end else begin
              act_push = 1'b1;
            end
          end
          syip_pkg::M_RPAREN: begin
            act_dec = 1'b1;
          end
          default: begin
            if (pend_ok) begin
              pnd_load  = 1'b1;
              act_clear = 1'b1;
              if (paren_depth != '0) begin
                pnd_err = syip_pkg::ERR_UNMATCHED_L;
              end else begin
                pnd_kind = syip_pkg::KIND_ACCEPT;
              end
            end
          end
        endcase
      end
      syip_pkg::S_FINISH: begin
        pnd_flush = pend_valid && can_emit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= syip_pkg::S_IDLE;
      mode            <= syip_pkg::M_END;
      stack_count     <= '0;
      paren_depth     <= '0;
      expect_operand  <= 1'b1;
      pend_valid      <= 1'b0;
      out_valid       <= 1'b0;
      prec_power      <= syip_pkg::CfgW'(4);
      prec_muldiv     <= syip_pkg::CfgW'(3);
      prec_addsub     <= syip_pkg::CfgW'(2);
      left_assoc_mask <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          syip_pkg::REG_PREC_POWER:  prec_power      <= cfg_data;
          syip_pkg::REG_PREC_MULDIV: prec_muldiv     <= cfg_data;
          syip_pkg::REG_PREC_ADDSUB: prec_addsub     <= cfg_data;
          default:                   left_assoc_mask <= cfg_data[syip_pkg::NumOps-1:0];
        endcase
      end
      if (act_start) begin
        mode <= start_mode;
      end
      if (act_operand) begin
        expect_operand <= 1'b0;
      end
      if (act_inc) begin
        paren_depth <= paren_depth + DEPTH_W'(1);
      end
      if (act_dec) begin
        paren_depth <= paren_depth - DEPTH_W'(1);
      end
      if (act_pop) begin
        stack_count <= cnt_m1;
      end
      if (act_push) begin
        stack_count    <= stack_count + CNT_W'(1);
        expect_operand <= 1'b1;
      end
      if (act_clear) begin
        stack_count    <= '0;
        paren_depth    <= '0;
        expect_operand <= 1'b1;
      end
      if (pnd_load) begin
        pend_valid <= 1'b1;
      end else if (pnd_flush) begin
        pend_valid <= 1'b0;
      end
      if (dir_load || pnd_flush || (pnd_load && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == syip_pkg::S_IDLE && in_valid) begin
      cmd_q     <= command;
      op_q      <= op_code;
      payload_q <= token_payload;
    end
    if (act_start) begin
      target <= start_target;
    end
    if (pnd_load) begin
      pend_kind <= pnd_kind;
      pend_op   <= pnd_op;
      pend_err  <= pnd_err;
    end
    if (dir_load) begin
      out_kind    <= dir_kind;
      out_op      <= syip_pkg::OP_NONE;
      out_payload <= (dir_kind == syip_pkg::KIND_OPERAND) ? payload_q : '0;
      error_code  <= dir_err;
      last        <= 1'b1;
    end else if (pnd_flush || (pnd_load && pend_valid)) begin
      out_kind    <= pend_kind;
      out_op      <= pend_op;
      out_payload <= '0;
      error_code  <= pend_err;
      last        <= pnd_flush;
    end
  end

endmodule

FILE: dv/syip_postfix_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the shunting-yard converter. It predicts the postfix stream
// for every accepted request and checks each accepted result against it.
// Depends on syip_pkg.
module syip_postfix_checker #(
  parameter int PAYLOAD_WIDTH = syip_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [syip_pkg::CmdW-1:0]    command,
  input  logic [syip_pkg::OpW-1:0]     op_code,
  input  logic [PAYLOAD_WIDTH-1:0]     token_payload,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [syip_pkg::KindW-1:0]   out_kind,
  input  logic [syip_pkg::OpW-1:0]     out_op,
  input  logic [PAYLOAD_WIDTH-1:0]     out_payload,
  input  logic [syip_pkg::ErrW-1:0]    error_code,
  input  logic                         last,
  input  logic                         cfg_we,
  input  logic [syip_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [syip_pkg::CfgW-1:0]    cfg_data,
  output int                           fail_count,
  output int                           pending
);
  import syip_pkg::*;

  localparam int StackDepth = STACK_DEPTH_DEF;
  localparam int MaxDepth   = MAX_PAREN_DEPTH_DEF;

  typedef struct packed {
    logic [KindW-1:0]         kind;
    logic [OpW-1:0]           op;
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic [ErrW-1:0]          err;
    logic                     last;
  } postfix_item_t;

  int unsigned      stk_prec [StackDepth];
  logic [OpW-1:0]   stk_op   [StackDepth];
  logic             stk_left [StackDepth];
  int unsigned      stk_count;
  int unsigned      paren_level;
  logic             wants_operand;
  logic [CfgW-1:0]  prec_power;
  logic [CfgW-1:0]  prec_muldiv;
  logic [CfgW-1:0]  prec_addsub;
  logic [NumOps-1:0] left_mask;

  postfix_item_t expected_postfix[$];
  postfix_item_t step_results[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic void emit_postfix(input logic [KindW-1:0] k, input logic [OpW-1:0] o,
                                       input logic [PAYLOAD_WIDTH-1:0] p,
                                       input logic [ErrW-1:0] e);
    postfix_item_t r;
    r.kind = k;
    r.op = o;
    r.payload = p;
    r.err = e;
    r.last = 1'b0;
    step_results = {step_results, r};
  endfunction

  function automatic void clear_state();
    stk_count = 0;
    paren_level = 0;
    wants_operand = 1'b1;
  endfunction

  function automatic void raise_error(input logic [ErrW-1:0] e);
    emit_postfix(KIND_ERROR, OP_NONE, '0, e);
    clear_state();
  endfunction

  // Entries leave while they bind tighter than the incoming precedence, or
  // bind equally and were pushed left associative.
  function automatic void pop_stacked(input int unsigned p);
    while (stk_count > 0) begin
      if (!(stk_prec[stk_count-1] > p || (stk_prec[stk_count-1] == p && stk_left[stk_count-1])))
        break;
      emit_postfix(KIND_OPERATOR, stk_op[stk_count-1], '0, ERR_NONE);
      stk_count--;
    end
  endfunction

  function automatic int unsigned base_prec(input logic [OpW-1:0] o);
    if (o <= OP_CARET) return prec_power;
    if (o <= OP_DIV) return prec_muldiv;
    return prec_addsub;
  endfunction

  function automatic void shunt_token(input logic [CmdW-1:0] c, input logic [OpW-1:0] o,
                                      input logic [PAYLOAD_WIDTH-1:0] p);
    int unsigned lvl_prec;
    step_results.delete();
    if (c > CMD_END) return;
    if (wants_operand) begin
      if (c == CMD_OPERAND) begin
        emit_postfix(KIND_OPERAND, OP_NONE, p, ERR_NONE);
        wants_operand = 1'b0;
      end else if (c == CMD_LPAREN) begin
        if (paren_level >= MaxDepth) raise_error(ERR_DEPTH_OVF);
        else paren_level++;
      end else begin
        raise_error(ERR_OPERAND_POS);
      end
    end else if (c == CMD_OPERAND || c == CMD_LPAREN) begin
      raise_error(ERR_OPERATOR_POS);
    end else if (c == CMD_OPERATOR) begin
      if (o >= NumOps) begin
        raise_error(ERR_OPERATOR_POS);
      end else begin
        lvl_prec = base_prec(o) + LevelStep * paren_level;
        pop_stacked(lvl_prec);
        if (stk_count >= StackDepth) begin
          raise_error(ERR_STACK_OVF);
        end else begin
          stk_prec[stk_count] = lvl_prec;
          stk_op[stk_count] = o;
          stk_left[stk_count] = left_mask[o];
          stk_count++;
          wants_operand = 1'b1;
        end
      end
    end else if (c == CMD_RPAREN) begin
      if (paren_level == 0) begin
        raise_error(ERR_UNMATCHED_R);
      end else begin
        pop_stacked(LevelStep * paren_level);
        paren_level--;
      end
    end else begin
      while (stk_count > 0) begin
        stk_count--;
        emit_postfix(KIND_OPERATOR, stk_op[stk_count], '0, ERR_NONE);
      end
      if (paren_level != 0) begin
        raise_error(ERR_UNMATCHED_L);
      end else begin
        emit_postfix(KIND_ACCEPT, OP_NONE, '0, ERR_NONE);
        clear_state();
      end
    end
    if (step_results.size() > 0) begin
      step_results[step_results.size() - 1].last = 1'b1;
    end
    expected_postfix = {expected_postfix, step_results};
  endfunction

  always @(posedge clk) begin : watch
    postfix_item_t got;
    postfix_item_t want;
    if (rst) begin
      prec_power = 7'd4;
      prec_muldiv = 7'd3;
      prec_addsub = 7'd2;
      left_mask = '0;
      clear_state();
      expected_postfix.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PREC_POWER:  prec_power = cfg_data;
          REG_PREC_MULDIV: prec_muldiv = cfg_data;
          REG_PREC_ADDSUB: prec_addsub = cfg_data;
          REG_LEFT_MASK:   left_mask = cfg_data[NumOps-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) shunt_token(command, op_code, token_payload);
      if (out_valid && !out_stall) begin
        got.kind = out_kind;
        got.op = out_op;
        got.payload = out_payload;
        got.err = error_code;
        got.last = last;
        if (expected_postfix.size() == 0) begin
          $display("%0t: unexpected result kind %0d op %0d payload %h err %0d last %0d",
                   $time, got.kind, got.op, got.payload, got.err, got.last);
          fail_count = fail_count + 1;
        end else begin
          want = expected_postfix.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected kind %0d op %0d payload %h err %0d last %0d",
                     $time, want.kind, want.op, want.payload, want.err, want.last);
            $display("%0t:                  actual   kind %0d op %0d payload %h err %0d last %0d",
                     $time, got.kind, got.op, got.payload, got.err, got.last);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending = expected_postfix.size();
  end

endmodule

FILE: dv/shunting_yard_infix_to_postfix_tb.sv
`timescale 1ns / 100ps
// Testbench top for the shunting-yard converter: drives token requests and
// register writes with random idling and output stalls, and reports the verdict.
// Depends on syip_pkg, shunting_yard_infix_to_postfix and syip_postfix_checker.
module shunting_yard_infix_to_postfix_tb;
  import syip_pkg::*;

  localparam int PayloadW    = PAYLOAD_WIDTH_DEF;
  localparam int SettleCycles = 60;
  localparam int LongHold    = 300;
  localparam int PhaseItems  = 20;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [CmdW-1:0]     command;
  logic [OpW-1:0]      op_code;
  logic [PayloadW-1:0] token_payload;
  logic                out_valid;
  logic                out_stall;
  logic [KindW-1:0]    out_kind;
  logic [OpW-1:0]      out_op;
  logic [PayloadW-1:0] out_payload;
  logic [ErrW-1:0]     error_code;
  logic                last;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_data;
  int                  fail_count;
  int                  pending;

  int                  hold_requests;
  int                  burst_left;
  int                  items_sent;
  int                  expr_count;
  logic [NumOps-1:0]   cur_mask;

  shunting_yard_infix_to_postfix u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .op_code(op_code), .token_payload(token_payload),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_op(out_op), .out_payload(out_payload),
    .error_code(error_code), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  syip_postfix_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .op_code(op_code), .token_payload(token_payload),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_op(out_op), .out_payload(out_payload),
    .error_code(error_code), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // The output side alternates stall patterns and serves long hold requests.
  initial begin : receiver
    int seg;
    int mode;
    int served;
    served = 0;
    out_stall = 1'b0;
    forever begin
      if (served != hold_requests) begin
        served++;
        repeat (LongHold) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        seg = $urandom_range(4, 40);
        mode = $urandom_range(0, 3);
        repeat (seg) begin
          @(negedge clk);
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  function automatic logic [PayloadW-1:0] random_payload();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_token(input logic [CmdW-1:0] c, input logic [OpW-1:0] o,
                            input logic [PayloadW-1:0] p);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    command <= c;
    op_code <= o;
    token_payload <= p;
    burst_left--;
    if (c <= CMD_END) items_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering requests, wait for every expected result, then let any
  // result-free request still in flight finish.
  task automatic await_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic set_config(input logic [CfgW-1:0] pw, input logic [CfgW-1:0] md,
                            input logic [CfgW-1:0] as, input logic [NumOps-1:0] mask);
    put_reg(REG_PREC_POWER, pw);
    put_reg(REG_PREC_MULDIV, md);
    put_reg(REG_PREC_ADDSUB, as);
    put_reg(REG_LEFT_MASK, CfgW'(mask));
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_mask = mask;
  endtask

  function automatic logic [OpW-1:0] random_op();
    return OpW'($urandom_range(0, NumOps - 1));
  endfunction

  task automatic send_noise();
    send_token(CmdW'($urandom_range(0, 7)), OpW'($urandom_range(0, 7)), random_payload());
  endtask

  // Well-formed expressions dominate; every third one runs deep, toward or past the
  // size of the operator stack or the nesting depth, and a few carry broken tokens.
  task automatic next_expression();
    int n;
    int lvl;
    int k;
    logic [OpW-1:0] op;
    expr_count++;
    if (expr_count % 6 == 0) begin
      k = ($urandom_range(0, 1) == 0) ? 17 : $urandom_range(12, 16);
      op = random_op();
      repeat (4) if (cur_mask[op]) op = random_op();
      send_token(CMD_OPERAND, OP_NONE, random_payload());
      repeat (k) begin
        send_token(CMD_OPERATOR, ($urandom_range(0, 3) == 0) ? random_op() : op, random_payload());
        send_token(CMD_OPERAND, OP_NONE, random_payload());
      end
      send_token(CMD_END, OP_NONE, random_payload());
    end else if (expr_count % 6 == 3) begin
      k = ($urandom_range(0, 1) == 0) ? 16 : $urandom_range(12, 15);
      repeat (k) begin
        send_token(CMD_OPERAND, OP_NONE, random_payload());
        send_token(CMD_OPERATOR, random_op(), random_payload());
        send_token(CMD_LPAREN, OP_NONE, random_payload());
      end
      send_token(CMD_OPERAND, OP_NONE, random_payload());
      repeat (k) send_token(CMD_RPAREN, OP_NONE, random_payload());
      send_token(CMD_END, OP_NONE, random_payload());
    end else if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) send_noise();
    end else begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
      lvl = 0;
      for (int i = 0; i < n; i++) begin
        while (lvl < MAX_PAREN_DEPTH_DEF && $urandom_range(0, 3) == 0) begin
          send_token(CMD_LPAREN, OP_NONE, random_payload());
          lvl++;
        end
        send_token(CMD_OPERAND, OP_NONE, random_payload());
        while (lvl > 0 && $urandom_range(0, 2) == 0) begin
          send_token(CMD_RPAREN, OP_NONE, random_payload());
          lvl--;
        end
        if (i < n - 1) send_token(CMD_OPERATOR, random_op(), random_payload());
        if ($urandom_range(0, 24) == 0) send_noise();
      end
      if ($urandom_range(0, 7) != 0)
        repeat (lvl) send_token(CMD_RPAREN, OP_NONE, random_payload());
      send_token(CMD_END, OP_NONE, random_payload());
    end
  endtask

  initial begin : stimulus
    int target;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_OPERAND;
    op_code = OP_NONE;
    token_payload = '0;
    cfg_we = 1'b0;
    cfg_index = REG_PREC_POWER;
    cfg_data = '0;
    hold_requests = 0;
    burst_left = 0;
    items_sent = 0;
    expr_count = 0;
    cur_mask = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed requests at the reset register values.
    send_token(CMD_END, OP_NONE, '0);
    send_token(CMD_OPERAND, OP_NONE, '0);
    send_token(CMD_OPERATOR, OP_DSTAR, '1);
    send_token(CMD_LPAREN, OP_NONE, '0);
    send_token(CMD_OPERAND, OP_NONE, '1);
    send_token(CMD_OPERATOR, OP_MUL, '0);
    send_token(CMD_OPERAND, OP_NONE, $urandom);
    send_token(CMD_RPAREN, OP_NONE, '0);
    send_token(CMD_OPERATOR, OP_CARET, '0);
    send_token(CMD_OPERAND, OP_NONE, $urandom);
    send_token(CMD_OPERATOR, OP_DIV, '0);
    send_token(CMD_OPERAND, OP_NONE, $urandom);
    send_token(CMD_OPERATOR, OP_ADD, '0);
    send_token(CMD_OPERAND, OP_NONE, $urandom);
    send_token(CMD_OPERATOR, OP_SUB, '0);
    send_token(CMD_OPERAND, OP_NONE, $urandom);
    send_token(CMD_END, OP_NONE, '1);
    send_token(CmdW'(5), OP_NONE, '1);
    send_token(CmdW'(7), OpW'(7), '1);
    send_token(CMD_OPERAND, OP_NONE, $urandom);
    send_token(CMD_OPERAND, OP_NONE, $urandom);
    send_token(CMD_OPERAND, OP_NONE, $urandom);
    send_token(CMD_OPERATOR, OpW'(6), '0);
    send_token(CMD_OPERAND, OP_NONE, $urandom);
    send_token(CMD_RPAREN, OP_NONE, '0);
    send_token(CMD_LPAREN, OP_NONE, '0);
    send_token(CMD_OPERAND, OP_NONE, $urandom);
    send_token(CMD_END, OP_NONE, '0);
    await_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(7'd4, 7'd3, 7'd2, 6'd0);
        1: set_config(7'd99, 7'd99, 7'd99, 6'h3F);
        2: set_config(7'd1, 7'd1, 7'd1, 6'd0);
        3: set_config(7'd1, 7'd50, 7'd99, 6'h2A);
        default: set_config(CfgW'($urandom_range(1, 99)), CfgW'($urandom_range(1, 99)),
                            CfgW'($urandom_range(1, 99)), NumOps'($urandom_range(0, 63)));
      endcase
      if (phase == 0 || phase == 4) hold_requests++;
      target = items_sent + PhaseItems;
      while (items_sent < target) next_expression();
      await_idle();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
